// File: sv/bmrs_pkg.sv
// Shared types and constants of the bitmap range set/clear core.
// Used by the request channel interface and the top level.
`timescale 1ns / 1ps

package bmrs_pkg;

   localparam int KIND_W             = 3;
   localparam int INDEX_W            = 13;
   localparam int WORD_BITS_DEFAULT  = 64;
   localparam int WORD_COUNT_DEFAULT = 64;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE_BIT   = 3'd0,
      KIND_WRITE_RANGE = 3'd1,
      KIND_READ_BIT    = 3'd2,
      KIND_ALL_ZERO    = 3'd3,
      KIND_ALL_ONE     = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// File: sv/bmrs_req_if.sv
// Request channel of the bitmap core: valid/ready plus one operation.
// Depends on bmrs_pkg for field widths.
`timescale 1ns / 1ps

interface bmrs_req_if;
   logic                         valid;
   logic                         ready;
   logic [bmrs_pkg::KIND_W-1:0]  kind;
   logic [bmrs_pkg::INDEX_W-1:0] first_index;
   logic [bmrs_pkg::INDEX_W-1:0] end_index;
   logic                         bit_value;

   modport source (output valid, kind, first_index, end_index, bit_value, input ready);
   modport sink   (input valid, kind, first_index, end_index, bit_value, output ready);
endinterface

// File: sv/bmrs_rsp_if.sv
// Response channel of the bitmap core: valid/ready plus the one-bit answer.
// Stands alone; no package items needed.
`timescale 1ns / 1ps

interface bmrs_rsp_if;
   logic valid;
   logic ready;
   logic answer;

   modport source (output valid, answer, input ready);
   modport sink   (input valid, answer, output ready);
endinterface

// File: sv/bmrs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bmrs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bitmap_range_set_clear_core.sv
// Bitmap of up to WORD_BITS * WORD_COUNT bits kept in one word RAM, bit i in word i / WORD_BITS.
// Each request transaction writes a bit or a range, reads a bit, or asks whether every bit
// below the configured length is zero or one, and gives exactly one response transaction.
// The core handles one request at a time: it walks the RAM from word 0, one word per cycle
// through the single read port, up to the last word the operation touches, and writes each
// modified word back in the following cycle. A new request is taken as soon as the result
// sits in the output register. After reset a clearing pass writes zero to every word, during
// which no request is taken. The length register is written through csr_wr_en/csr_wr_data;
// the user must keep it written only while the core is idle, as the core does not enforce this.
`timescale 1ns / 1ps

module bitmap_range_set_clear_core #(
   parameter int WORD_BITS  = bmrs_pkg::WORD_BITS_DEFAULT,
   parameter int WORD_COUNT = bmrs_pkg::WORD_COUNT_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   bmrs_req_if.sink                     req_ch,
   bmrs_rsp_if.source                   rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [bmrs_pkg::INDEX_W-1:0] csr_wr_data
);

   localparam int AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int CAP    = WORD_BITS * WORD_COUNT;
   localparam int CAP_W  = $clog2(CAP + 1);
   localparam int POS_W  = (CAP_W > bmrs_pkg::INDEX_W + 1) ? CAP_W : bmrs_pkg::INDEX_W + 1;
   localparam int OFF_W  = $clog2(WORD_BITS + 1);
   localparam logic [POS_W-1:0] CAP_P  = POS_W'(CAP);
   localparam logic [POS_W-1:0] WB_P   = POS_W'(WORD_BITS);
   localparam logic [AW-1:0]    LAST_W = AW'(WORD_COUNT - 1);

   bmrs_pkg::state_type state_ff, state_in;
   bmrs_pkg::kind_type  op_ff, op_in;

   logic [bmrs_pkg::INDEX_W-1:0] len_ff;
   logic [POS_W-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [POS_W-1:0]     base_ff, base_in;
   logic [AW-1:0]        w_ff, w_in;
   logic                 val_ff, val_in;
   logic                 acc_ff, acc_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic [AW-1:0]        s1_addr_ff;
   logic [WORD_BITS-1:0] s1_mask_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 answer_ff, answer_in;

   logic [POS_W-1:0]     used_len, first_e, end_e, base_next, lo_diff, hi_diff;
   logic [OFF_W-1:0]     lo_rel, hi_rel;
   logic [WORD_BITS-1:0] mask_word, rd_data, wr_data, masked;
   logic                 issue, last_word, req_accept;
   logic                 mem_we, mem_re;
   logic [AW-1:0]        wr_addr;

   // Length in use, saturated to the size of the store.
   always_comb begin
      used_len = (POS_W'(len_ff) < CAP_P) ? POS_W'(len_ff) : CAP_P;
      first_e  = POS_W'(req_ch.first_index);
      end_e    = POS_W'(req_ch.end_index);
   end

   // Mask of the bits of word w_ff that fall inside [lo_ff, hi_ff).
   always_comb begin
      base_next = base_ff + WB_P;
      lo_diff   = (lo_ff > base_ff) ? lo_ff - base_ff : '0;
      hi_diff   = (hi_ff >= base_next) ? WB_P : hi_ff - base_ff;
      lo_rel    = lo_diff[OFF_W-1:0];
      hi_rel    = hi_diff[OFF_W-1:0];
      for (int j = 0; j < WORD_BITS; j++) begin
         mask_word[j] = (OFF_W'(j) >= lo_rel) && (OFF_W'(j) < hi_rel);
      end
      issue     = (lo_ff < hi_ff) && (base_ff < hi_ff) && (lo_ff < base_next);
      last_word = (base_next >= hi_ff) || (w_ff == LAST_W);
   end

   assign req_accept = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      base_in      = base_ff;
      w_in         = w_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      s1_valid_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      answer_in    = answer_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      wr_addr      = s1_addr_ff;
      wr_data      = '0;
      masked       = rd_data & s1_mask_ff;

      // Second stage: the word read last cycle is checked or written back.
      if (s1_valid_ff) begin
         case (op_ff)
            bmrs_pkg::KIND_WRITE_BIT, bmrs_pkg::KIND_WRITE_RANGE: begin
               mem_we  = 1'b1;
               wr_data = val_ff ? (rd_data | s1_mask_ff) : (rd_data & ~s1_mask_ff);
            end
            bmrs_pkg::KIND_READ_BIT: begin
               acc_in = |masked;
            end
            bmrs_pkg::KIND_ALL_ZERO: begin
               if (masked != '0) begin
                  acc_in = 1'b0;
               end
            end
            bmrs_pkg::KIND_ALL_ONE: begin
               if (masked != s1_mask_ff) begin
                  acc_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         bmrs_pkg::ST_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = w_ff;
            wr_data = '0;
            if (w_ff == LAST_W) begin
               w_in     = '0;
               state_in = bmrs_pkg::ST_IDLE;
            end else begin
               w_in = w_ff + AW'(1);
            end
         end
         bmrs_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in   = bmrs_pkg::kind_type'(req_ch.kind);
               val_in  = req_ch.bit_value;
               w_in    = '0;
               base_in = '0;
               acc_in  = 1'b0;
               lo_in   = '0;
               hi_in   = '0;
               case (req_ch.kind)
                  bmrs_pkg::KIND_WRITE_BIT, bmrs_pkg::KIND_READ_BIT: begin
                     if (first_e < used_len) begin
                        lo_in = first_e;
                        hi_in = first_e + POS_W'(1);
                     end
                  end
                  bmrs_pkg::KIND_WRITE_RANGE: begin
                     lo_in = (first_e < used_len) ? first_e : used_len;
                     hi_in = (end_e < used_len) ? end_e : used_len;
                  end
                  bmrs_pkg::KIND_ALL_ZERO, bmrs_pkg::KIND_ALL_ONE: begin
                     hi_in  = used_len;
                     acc_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
               state_in = bmrs_pkg::ST_SWEEP;
            end
         end
         bmrs_pkg::ST_SWEEP: begin
            mem_re      = issue;
            s1_valid_in = issue;
            if (last_word) begin
               state_in = bmrs_pkg::ST_DRAIN;
            end else begin
               w_in    = w_ff + AW'(1);
               base_in = base_next;
            end
         end
         bmrs_pkg::ST_DRAIN: begin
            state_in = bmrs_pkg::ST_DONE;
         end
         bmrs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               answer_in    = acc_ff;
               state_in     = bmrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmrs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmrs_pkg::ST_CLEAR;
         w_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      base_ff    <= base_in;
      val_ff     <= val_in;
      acc_ff     <= acc_in;
      answer_ff  <= answer_in;
      s1_addr_ff <= w_ff;
      s1_mask_ff <= mask_word;
   end

   bmrs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_words (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (mem_re),
      .rd_addr (w_ff),
      .rd_data (rd_data)
   );

   assign req_ch.ready  = (state_ff == bmrs_pkg::ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.answer = answer_ff;

`ifndef SYNTH
   // Write-back only follows a read issued during the sweep.
   a_s1_from_sweep: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(state_ff) == bmrs_pkg::ST_SWEEP)
      else $error("second stage active without a sweep read");

   // The RAM is never written while a new transaction can be accepted.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmrs_pkg::ST_IDLE) |-> !mem_we)
      else $error("RAM write while idle");

   // An accepted transaction always starts a sweep at word zero.
   a_accept_sweep: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == bmrs_pkg::ST_SWEEP) && (w_ff == '0) && (base_ff == '0))
      else $error("accepted transaction did not start a sweep");

   // The bit position tracks the word index during the sweep.
   a_base_track: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmrs_pkg::ST_SWEEP) |-> base_ff == POS_W'(w_ff) * WB_P)
      else $error("sweep bit position out of step with word index");

   // A result is only loaded when the output register is free or being emptied.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> rsp_valid_ff && $stable(answer_ff))
      else $error("pending response overwritten");
`endif

endmodule

// File: verif/bitmap_range_set_clear_core_tb.sv
// Self-checking testbench for bitmap_range_set_clear_core: directed table, then random phases.
// Depends on bmrs_pkg, bmrs_req_if, bmrs_rsp_if and the core; keeps a shadow copy of the bitmap.
`timescale 1ns / 1ps

module bitmap_range_set_clear_core_tb;

   localparam int KIND_W     = bmrs_pkg::KIND_W;
   localparam int INDEX_W    = bmrs_pkg::INDEX_W;
   localparam int WORD_BITS  = bmrs_pkg::WORD_BITS_DEFAULT;
   localparam int WORD_COUNT = bmrs_pkg::WORD_COUNT_DEFAULT;
   localparam int MAP_BITS   = WORD_BITS * WORD_COUNT;
   localparam int INDEX_MAX  = (1 << INDEX_W) - 1;

   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

   localparam int     PHASE_COUNT     = 8;
   localparam int     ITEMS_PER_PHASE = 100;
   localparam int     QUIET_PHASE     = 3;
   localparam int     HOLD_PHASE      = 5;
   localparam int     HOLD_CYCLES     = 400;
   localparam int     MAX_GAP         = 18;
   localparam longint RUN_LIMIT_NS    = 64'd20_000_000;

   typedef struct {
      bit                 is_config;
      logic [INDEX_W-1:0] length;
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] first_index;
      logic [INDEX_W-1:0] end_index;
      logic               bit_value;
      bit                 by_hand;
      logic               answer;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [INDEX_W-1:0] csr_wr_data;

   bmrs_req_if req_if ();
   bmrs_rsp_if rsp_if ();

   bitmap_range_set_clear_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow of the core: bitmap words and the length register.
   logic [WORD_BITS-1:0] shadow_words [WORD_COUNT];
   logic [INDEX_W-1:0]   length_cfg;

   logic             pending_answers [$];
   directed_row_type directed_rows [$];
   int               error_count;
   int               responses_seen;
   bit               quiet;
   bit               hold_pending;
   bit               valid_held;
   bit               sticky_value;
   logic             wanted_answer;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("bitmap_range_set_clear_core_tb: done, errors");
      $finish;
   end

   function automatic int used_length();
      return (length_cfg > MAP_BITS) ? MAP_BITS : int'(length_cfg);
   endfunction

   function automatic logic apply_to_shadow(input logic [KIND_W-1:0] kind,
                                            input logic [INDEX_W-1:0] first_index,
                                            input logic [INDEX_W-1:0] end_index,
                                            input logic bit_value);
      int   used;
      int   lo;
      int   hi;
      int   i;
      logic result;
      used   = used_length();
      result = 1'b0;
      case (kind)
         bmrs_pkg::KIND_WRITE_BIT: begin
            if (first_index < used)
               shadow_words[first_index / WORD_BITS][first_index % WORD_BITS] = bit_value;
         end
         bmrs_pkg::KIND_WRITE_RANGE: begin
            lo = (first_index > used) ? used : int'(first_index);
            hi = (end_index > used) ? used : int'(end_index);
            for (i = lo; i < hi; i++)
               shadow_words[i / WORD_BITS][i % WORD_BITS] = bit_value;
         end
         bmrs_pkg::KIND_READ_BIT: begin
            if (first_index < used)
               result = shadow_words[first_index / WORD_BITS][first_index % WORD_BITS];
         end
         bmrs_pkg::KIND_ALL_ZERO, bmrs_pkg::KIND_ALL_ONE: begin
            // Bits at or past the length in use do not take part in either query.
            result = 1'b1;
            for (i = 0; i < used; i++)
               if (shadow_words[i / WORD_BITS][i % WORD_BITS] !=
                   (kind == bmrs_pkg::KIND_ALL_ONE))
                  result = 1'b0;
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   function automatic void add_length(input int length);
      directed_row_type row;
      row           = '{default: '0};
      row.is_config = 1'b1;
      row.length    = INDEX_W'(length);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_op(input logic [KIND_W-1:0] kind, input int first_index,
                                  input int end_index, input logic bit_value,
                                  input bit by_hand, input logic answer);
      directed_row_type row;
      row             = '{default: '0};
      row.kind        = kind;
      row.first_index = INDEX_W'(first_index);
      row.end_index   = INDEX_W'(end_index);
      row.bit_value   = bit_value;
      row.by_hand     = by_hand;
      row.answer      = answer;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index(input int used);
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r < 5)
         v = $urandom_range(0, used);
      else if (r < 7)
         v = used + $urandom_range(0, 2) - 1;
      else
         v = $urandom_range(0, INDEX_MAX);
      if (v < 0)
         v = 0;
      if (v > INDEX_MAX)
         v = INDEX_MAX;
      return INDEX_W'(v);
   endfunction

   task automatic report_mismatch(input string what, input logic got, input logic want);
      error_count++;
      if (error_count <= 40)
         $display("%0t: response %0d: %s (got %b, expected %b)",
                  $time, responses_seen, what, got, want);
   endtask

   // Presents one request transaction and records its expected answer once it is taken.
   task automatic push_request(input logic [KIND_W-1:0] kind,
                               input logic [INDEX_W-1:0] first_index,
                               input logic [INDEX_W-1:0] end_index,
                               input logic bit_value, input bit by_hand,
                               input logic hand_answer);
      int   gap;
      logic predicted;
      if (quiet || $urandom_range(0, 3) == 0)
         gap = 0;
      else
         gap = $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         if (valid_held)
            req_if.valid <= 1'b0;
         valid_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind;
      req_if.first_index <= first_index;
      req_if.end_index   <= end_index;
      req_if.bit_value   <= bit_value;
      valid_held = 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = apply_to_shadow(kind, first_index, end_index, bit_value);
      pending_answers.push_back(by_hand ? hand_answer : predicted);
   endtask

   task automatic drain();
      if (valid_held)
         req_if.valid <= 1'b0;
      valid_held = 1'b0;
      while (pending_answers.size() != 0)
         @(posedge clock);
   endtask

   // The length register is only written once the core has nothing in flight.
   task automatic write_length(input logic [INDEX_W-1:0] length);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= length;
      length_cfg = length;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic draw_request(output logic [KIND_W-1:0] kind,
                               output logic [INDEX_W-1:0] first_index,
                               output logic [INDEX_W-1:0] end_index,
                               output logic bit_value);
      int r;
      int used;
      used        = used_length();
      r           = $urandom_range(0, 99);
      first_index = pick_index(used);
      end_index   = pick_index(used);
      bit_value   = ($urandom_range(0, 4) == 0) ? !sticky_value : sticky_value;
      if (r < 25)
         kind = bmrs_pkg::KIND_WRITE_BIT;
      else if (r < 47)
         kind = bmrs_pkg::KIND_WRITE_RANGE;
      else if (r < 67)
         kind = bmrs_pkg::KIND_READ_BIT;
      else if (r < 79)
         kind = bmrs_pkg::KIND_ALL_ZERO;
      else if (r < 91)
         kind = bmrs_pkg::KIND_ALL_ONE;
      else if (r < 97) begin
         // Fill the whole map so that later queries can come out true.
         kind         = bmrs_pkg::KIND_WRITE_RANGE;
         first_index  = '0;
         end_index    = ($urandom_range(0, 1) == 0) ? INDEX_W'(used) : INDEX_W'(INDEX_MAX);
         bit_value    = 1'($urandom_range(0, 1));
         sticky_value = bit_value;
      end else
         kind = KIND_SPARE_FIRST + KIND_W'($urandom_range(0, KIND_SPARE_LAST - KIND_SPARE_FIRST));
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         responses_seen++;
         if (pending_answers.size() == 0)
            report_mismatch("response with no request outstanding", rsp_if.answer, 1'bx);
         else begin
            wanted_answer = pending_answers.pop_front();
            if (rsp_if.answer !== wanted_answer)
               report_mismatch("answer differs", rsp_if.answer, wanted_answer);
         end
      end
   end

   // Response side: random stalls, one long hold-off while requests keep coming.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_pending) begin
            stall        = HOLD_CYCLES;
            hold_pending = 1'b0;
         end else if (quiet || $urandom_range(0, 3) == 0)
            stall = 0;
         else
            stall = $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
      end
   end

   initial begin
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] first_index;
      logic [INDEX_W-1:0] end_index;
      logic               bit_value;
      int                 length;
      error_count    = 0;
      responses_seen = 0;
      quiet          = 1'b0;
      hold_pending   = 1'b0;
      valid_held     = 1'b0;
      sticky_value   = 1'b0;
      length_cfg     = '0;
      foreach (shadow_words[w])
         shadow_words[w] = '0;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_if.valid       <= 1'b0;
      req_if.kind        <= bmrs_pkg::KIND_WRITE_BIT;
      req_if.first_index <= '0;
      req_if.end_index   <= '0;
      req_if.bit_value   <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // With length zero both queries hold and single-bit accesses are out of range.
      add_op(bmrs_pkg::KIND_ALL_ZERO, 0, 0, 1'b0, 1, 1'b1);
      add_op(bmrs_pkg::KIND_ALL_ONE, 0, 0, 1'b0, 1, 1'b1);
      add_op(bmrs_pkg::KIND_WRITE_BIT, 0, 0, 1'b1, 1, 1'b0);
      add_op(bmrs_pkg::KIND_READ_BIT, 0, 0, 1'b0, 1, 1'b0);
      add_length(MAP_BITS);
      add_op(bmrs_pkg::KIND_ALL_ZERO, 0, 0, 1'b0, 1, 1'b1);
      add_op(bmrs_pkg::KIND_ALL_ONE, 0, 0, 1'b0, 1, 1'b0);
      add_op(bmrs_pkg::KIND_WRITE_RANGE, 0, MAP_BITS, 1'b1, 1, 1'b0);
      add_op(bmrs_pkg::KIND_ALL_ONE, 0, 0, 1'b0, 1, 1'b1);
      add_op(bmrs_pkg::KIND_READ_BIT, MAP_BITS - 1, 0, 1'b0, 1, 1'b1);
      add_op(bmrs_pkg::KIND_WRITE_RANGE, 100, 100, 1'b0, 1, 1'b0);
      add_op(bmrs_pkg::KIND_WRITE_RANGE, 200, 150, 1'b0, 1, 1'b0);
      add_op(bmrs_pkg::KIND_ALL_ONE, 0, 0, 1'b0, 1, 1'b1);
      add_op(bmrs_pkg::KIND_WRITE_BIT, MAP_BITS - 1, 0, 1'b0, 1, 1'b0);
      add_op(bmrs_pkg::KIND_WRITE_RANGE, WORD_BITS - 1, 2 * WORD_BITS + 1, 1'b0, 1, 1'b0);
      add_op(bmrs_pkg::KIND_READ_BIT, WORD_BITS - 2, 0, 1'b0, 0, 1'b0);
      add_op(bmrs_pkg::KIND_READ_BIT, WORD_BITS, 0, 1'b0, 0, 1'b0);
      add_op(bmrs_pkg::KIND_ALL_ONE, 0, 0, 1'b0, 0, 1'b0);
      add_op(KIND_SPARE_FIRST, INDEX_MAX, INDEX_MAX, 1'b1, 1, 1'b0);
      add_op(KIND_SPARE_LAST, 0, INDEX_MAX, 1'b1, 1, 1'b0);
      // A length beyond the store saturates to its size.
      add_length(INDEX_MAX);
      add_op(bmrs_pkg::KIND_WRITE_RANGE, 0, INDEX_MAX, 1'b0, 1, 1'b0);
      add_op(bmrs_pkg::KIND_ALL_ZERO, 0, 0, 1'b0, 1, 1'b1);
      add_op(bmrs_pkg::KIND_READ_BIT, INDEX_MAX, 0, 1'b0, 1, 1'b0);
      add_length(100);
      add_op(bmrs_pkg::KIND_WRITE_RANGE, 0, INDEX_MAX, 1'b1, 1, 1'b0);
      add_op(bmrs_pkg::KIND_ALL_ONE, 0, 0, 1'b0, 1, 1'b1);
      add_op(bmrs_pkg::KIND_READ_BIT, 99, 0, 1'b0, 1, 1'b1);
      add_op(bmrs_pkg::KIND_READ_BIT, 100, 0, 1'b0, 1, 1'b0);
      add_op(bmrs_pkg::KIND_WRITE_BIT, 5000, 0, 1'b0, 1, 1'b0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_config)
            write_length(directed_rows[i].length);
         else
            push_request(directed_rows[i].kind, directed_rows[i].first_index,
                         directed_rows[i].end_index, directed_rows[i].bit_value,
                         directed_rows[i].by_hand, directed_rows[i].answer);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       length = MAP_BITS;
            1:       length = 1;
            2:       length = WORD_BITS + 1;
            3:       length = 2 * WORD_BITS;
            4:       length = $urandom_range(0, INDEX_MAX);
            5:       length = INDEX_MAX;
            6:       length = $urandom_range(2, 300);
            default: length = WORD_BITS - 1;
         endcase
         write_length(INDEX_W'(length));
         quiet = (p == QUIET_PHASE);
         if (p == HOLD_PHASE)
            hold_pending = 1'b1;
         repeat (ITEMS_PER_PHASE) begin
            draw_request(kind, first_index, end_index, bit_value);
            push_request(kind, first_index, end_index, bit_value, 0, 1'b0);
         end
      end

      drain();
      repeat (WORD_COUNT + 8) @(posedge clock);
      if (error_count == 0)
         $display("bitmap_range_set_clear_core_tb: done, clean");
      else
         $display("bitmap_range_set_clear_core_tb: done, errors");
      $finish;
   end

endmodule
